### rtl/core/bgms_pkg.sv
`timescale 1ns / 1ps
package bgms_pkg;

  // fixed field widths
  localparam int ROW_W       = 64;
  localparam int ROW_IDX_W   = 10;
  localparam int GRID_W_W    = 7;
  localparam int GRID_H_W    = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_TDATA_W = 80;
  localparam int IN_TDATA_W  = 64;

  // row index reach of the 10-bit row number
  localparam int ROW_IDX_LIMIT = 1024;

  // window count at which the center cell is kept
  localparam logic [3:0] HIGH_COUNT = 4'd4;

  // smallest width and height in use
  localparam logic [GRID_W_W-1:0] MIN_WIDTH  = 7'd3;
  localparam logic [GRID_H_W-1:0] MIN_HEIGHT = 11'd3;

  // register reset values
  localparam logic [GRID_W_W-1:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [GRID_H_W-1:0] GRID_HEIGHT_RST = 11'd64;

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                 frame_end;
    logic [ROW_IDX_W-1:0] row_number;
    logic [ROW_W-1:0]     smoothed_cells;
  } result_t;

  // two results may enter the queue from one input row
  typedef struct packed {
    logic    wr0;
    logic    wr1;
    result_t res0;
    result_t res1;
  } queue_wr_t;

endpackage

### rtl/core/bgms_lane.sv
`timescale 1ns / 1ps
module bgms_lane (
  input  logic [8:0] window,
  input  logic       center,
  input  logic       active,
  output logic       smooth_bit
);
  import bgms_pkg::*;

  logic [3:0] count;

  // wall count over the 3x3 window
  always_comb begin
    count = 4'd0;
    for (int i = 0; i < 9; i++) begin
      count = count + {3'd0, window[i]};
    end
  end

  // above four walls set, below four clear, exactly four keeps the center; an inactive lane passes the center
  always_comb begin
    if (!active) begin
      smooth_bit = center;
    end else if (count > HIGH_COUNT) begin
      smooth_bit = 1'b1;
    end else if (count < HIGH_COUNT) begin
      smooth_bit = 1'b0;
    end else begin
      smooth_bit = center;
    end
  end

endmodule

### rtl/core/bgms_row.sv
`timescale 1ns / 1ps
module bgms_row #(
  parameter int MAX_WIDTH = 64
) (
  input  logic [bgms_pkg::ROW_W-1:0]    above,
  input  logic [bgms_pkg::ROW_W-1:0]    mid,
  input  logic [bgms_pkg::ROW_W-1:0]    below,
  input  logic [bgms_pkg::GRID_W_W-1:0] width_use,
  output logic [bgms_pkg::ROW_W-1:0]    smoothed
);
  import bgms_pkg::*;

  logic [ROW_W-1:0] lane_out;

  // one lane per interior column, border columns pass through
  for (genvar x = 0; x < ROW_W; x++) begin : g_col
    if (x >= 1 && x < MAX_WIDTH - 1) begin : g_lane
      logic act;
      assign act = (GRID_W_W'(x + 1) < width_use);
      bgms_lane u_lane (
        .window     ({above[x+1:x-1], mid[x+1:x-1], below[x+1:x-1]}),
        .center     (mid[x]),
        .active     (act),
        .smooth_bit (lane_out[x])
      );
    end else begin : g_pass
      assign lane_out[x] = mid[x];
    end
  end

  // merge lanes and clear columns at or beyond the width
  always_comb begin
    for (int x = 0; x < ROW_W; x++) begin
      smoothed[x] = lane_out[x] & (GRID_W_W'(x) < width_use);
    end
  end

endmodule

### rtl/core/bgms_out_fifo.sv
`timescale 1ns / 1ps
module bgms_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  bgms_pkg::queue_wr_t wr,
  output logic                room2,
  output logic                out_valid,
  input  logic                out_ready,
  output bgms_pkg::result_t   out_res
);
  import bgms_pkg::*;

  result_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr;
  logic [FIFO_PTR_W-1:0] rptr;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_CNT_W-1:0] count_next;
  logic [FIFO_CNT_W-1:0] n_wr;
  logic                  rd;

  assign rd        = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = mem[rptr];
  assign room2     = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign n_wr      = FIFO_CNT_W'(wr.wr0) + FIFO_CNT_W'(wr.wr1);

  always_comb begin
    count_next = count + n_wr - FIFO_CNT_W'(rd);
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + n_wr[FIFO_PTR_W-1:0];
      rptr  <= rptr + FIFO_PTR_W'(rd);
      count <= count_next;
    end
  end

  // storage, up to two entries written per cycle
  always_ff @(posedge clk) begin
    if (wr.wr0) begin
      mem[wptr] <= wr.res0;
    end
    if (wr.wr1) begin
      mem[wptr + FIFO_PTR_W'(1)] <= wr.res1;
    end
  end

endmodule

### rtl/core/binary_grid_majority_smoother.sv
`timescale 1ns / 1ps
// ordering: results of row r enter the result queue as row r+1 is transferred, and leave it on m_axis
// throughput: one row per cycle; the last row of a frame yields two results,
// drained through a four-entry result queue that holds s_axis_tready low when short of room
// reset: rst (synchronous) empties the queue, restarts the frame and sets
// grid_width and grid_height to 64; a register write also restarts the frame
module binary_grid_majority_smoother #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_axis_tdata: row_cells[63:0]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [bgms_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // m_axis_tdata: smoothed_cells[63:0], row_number[73:64], zero fill[79:74]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [bgms_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we,
  input  logic [bgms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bgms_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bgms_pkg::*;

  localparam int HLIM = (MAX_HEIGHT < ROW_IDX_LIMIT) ? MAX_HEIGHT : ROW_IDX_LIMIT;
  localparam logic [GRID_W_W-1:0] WIDTH_MAX  = GRID_W_W'(MAX_WIDTH);
  localparam logic [GRID_H_W-1:0] HEIGHT_MAX = GRID_H_W'(HLIM);

  logic [GRID_W_W-1:0]  grid_width;
  logic [GRID_H_W-1:0]  grid_height;
  logic [GRID_W_W-1:0]  width_use;
  logic [GRID_H_W-1:0]  height_use;
  logic [ROW_W-1:0]     row_mask;
  logic [ROW_W-1:0]     in_row;
  logic [ROW_W-1:0]     older_row;
  logic [ROW_W-1:0]     middle_row;
  logic [ROW_W-1:0]     smoothed;
  logic [ROW_IDX_W-1:0] rows_seen;
  logic                 accept;
  logic                 last_row;
  logic                 room2;
  queue_wr_t            qwr;
  result_t              out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[GRID_W_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturated width and height in use
  always_comb begin
    if (grid_width < MIN_WIDTH) begin
      width_use = MIN_WIDTH;
    end else if (grid_width > WIDTH_MAX) begin
      width_use = WIDTH_MAX;
    end else begin
      width_use = grid_width;
    end
    if (grid_height < MIN_HEIGHT) begin
      height_use = MIN_HEIGHT;
    end else if (grid_height > HEIGHT_MAX) begin
      height_use = HEIGHT_MAX;
    end else begin
      height_use = grid_height;
    end
  end

  // column mask for the width in use
  always_comb begin
    for (int x = 0; x < ROW_W; x++) begin
      row_mask[x] = (GRID_W_W'(x) < width_use);
    end
  end

  assign in_row        = s_axis_tdata[ROW_W-1:0] & row_mask;
  assign s_axis_tready = room2;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_row      = ({1'b0, rows_seen} + GRID_H_W'(1)) >= height_use;

  // lanes over the held rows and the incoming row
  bgms_row #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_row (
    .above     (older_row),
    .mid       (middle_row),
    .below     (in_row),
    .width_use (width_use),
    .smoothed  (smoothed)
  );

  // results entering the queue
  always_comb begin
    qwr.wr0                 = accept && (rows_seen != '0);
    qwr.wr1                 = accept && (rows_seen != '0) && last_row;
    qwr.res0.smoothed_cells = (rows_seen == ROW_IDX_W'(1)) ? middle_row : smoothed;
    qwr.res0.row_number     = rows_seen - ROW_IDX_W'(1);
    qwr.res0.frame_end      = 1'b0;
    qwr.res1.smoothed_cells = in_row;
    qwr.res1.row_number     = rows_seen;
    qwr.res1.frame_end      = 1'b1;
  end

  // row counter, restarted by a register write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      rows_seen <= '0;
    end else if (accept) begin
      if (rows_seen == '0) begin
        rows_seen <= ROW_IDX_W'(1);
      end else if (last_row) begin
        rows_seen <= '0;
      end else begin
        rows_seen <= rows_seen + ROW_IDX_W'(1);
      end
    end
  end

  // held rows
  always_ff @(posedge clk) begin
    if (accept) begin
      older_row  <= middle_row;
      middle_row <= in_row;
    end
  end

  bgms_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (qwr),
    .room2     (room2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - ROW_W - ROW_IDX_W){1'b0}},
                         out_res.row_number, out_res.smoothed_cells};
  assign m_axis_tlast = out_res.frame_end;

endmodule

### rtl/core/bgms_checker.sv
`timescale 1ns / 1ps
module bgms_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bgms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             cfg_we
);
  import bgms_pkg::*;

  logic                 out_xfer;
  logic [ROW_IDX_W-1:0] out_row;
  logic [ROW_IDX_W-1:0] prev_row;
  logic                 prev_last;
  logic                 seen;

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_row  = m_axis_tdata[ROW_W+ROW_IDX_W-1:ROW_W];

  // last delivered row within the current frame
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      seen <= 1'b0;
    end else if (out_xfer) begin
      seen <= 1'b1;
    end
    if (out_xfer) begin
      prev_row  <= out_row;
      prev_last <= m_axis_tlast;
    end
  end

  // no result survives a reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // rows of a frame come out in order
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_xfer && seen && !prev_last |-> out_row == prev_row + ROW_IDX_W'(1))
    else $error("row number out of sequence");

  // a frame has at least three rows
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_xfer && m_axis_tlast |-> out_row >= ROW_IDX_W'(2))
    else $error("frame end on too early a row");

endmodule

bind binary_grid_majority_smoother bgms_checker u_bgms_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_we        (cfg_we)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bgms_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int KEEP_COUNT   = 4;
  localparam int WIDTH_CAP    = 64;
  localparam int HEIGHT_CAP   = 1024;
  localparam int DRAIN_CYCLES = 6;
  // the longest quiet stretches come from random stalls at 86 percent idling on
  // either side; this limit lies far beyond them
  localparam int QUIET_LIMIT  = 4000;

  // expected result of one row, same fields as a transfer on m_axis
  typedef struct {
    logic [ROW_W-1:0]     cells;
    logic [ROW_IDX_W-1:0] row_number;
    logic                 frame_end;
  } smoothed_row_t;

  // predicts the smoothed rows and checks them in order
  class majority_scoreboard;
    logic [GRID_W_W-1:0] width_reg;
    logic [GRID_H_W-1:0] height_reg;
    logic [ROW_W-1:0]    above_row;
    logic [ROW_W-1:0]    center_row;
    int unsigned         row_idx;
    smoothed_row_t       expected_rows[$];
    int unsigned         errors;
    int unsigned         rows_in;
    int unsigned         rows_checked;
    int unsigned         frames_checked;
    int unsigned         cfg_writes;

    function new();
      width_reg      = GRID_WIDTH_RST;
      height_reg     = GRID_HEIGHT_RST;
      above_row      = '0;
      center_row     = '0;
      row_idx        = 0;
      errors         = 0;
      rows_in        = 0;
      rows_checked   = 0;
      frames_checked = 0;
      cfg_writes     = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function int unsigned pending();
      return expected_rows.size();
    endfunction

    // expectation goes to the tail of the queue
    function void add_expected(smoothed_row_t r);
      expected_rows.insert(expected_rows.size(), r);
    endfunction

    // a write restarts the frame and drops the held rows
    function void set_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_GRID_WIDTH) width_reg = value[GRID_W_W-1:0];
      else height_reg = value[GRID_H_W-1:0];
      above_row  = '0;
      center_row = '0;
      row_idx    = 0;
      cfg_writes++;
    endfunction

    function int unsigned width_now();
      int unsigned w;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > WIDTH_CAP) w = WIDTH_CAP;
      return w;
    endfunction

    function int unsigned height_now();
      int unsigned h;
      h = height_reg;
      if (h < 3) h = 3;
      if (h > HEIGHT_CAP) h = HEIGHT_CAP;
      return h;
    endfunction

    // 3x3 wall count per interior column: above 4 wall, below 4 floor, 4 keeps
    function logic [ROW_W-1:0] smooth_center(logic [ROW_W-1:0] above,
                                             logic [ROW_W-1:0] center,
                                             logic [ROW_W-1:0] below,
                                             int unsigned w);
      logic [ROW_W-1:0] res;
      int cnt;
      res = center;
      for (int x = 1; x + 1 < w; x++) begin
        cnt = 0;
        for (int b = x - 1; b <= x + 1; b++)
          cnt += int'(above[b]) + int'(center[b]) + int'(below[b]);
        if (cnt > KEEP_COUNT) res[x] = 1'b1;
        else if (cnt < KEEP_COUNT) res[x] = 1'b0;
      end
      return res;
    endfunction

    // one accepted input row: zero, one or two expected results
    function void note_row(logic [ROW_W-1:0] cells);
      int unsigned   w;
      int unsigned   h;
      logic [ROW_W-1:0] mask;
      logic [ROW_W-1:0] row;
      smoothed_row_t exp_row;
      w    = width_now();
      h    = height_now();
      mask = (w >= ROW_W) ? '1 : ((64'd1 << w) - 64'd1);
      row  = cells & mask;
      rows_in++;
      if (row_idx == 0) begin
        center_row = row;
        row_idx    = 1;
        return;
      end
      // top row passes through, later rows are smoothed
      if (row_idx == 1) exp_row.cells = center_row & mask;
      else exp_row.cells = smooth_center(above_row, center_row, row, w) & mask;
      exp_row.row_number = ROW_IDX_W'(row_idx - 1);
      exp_row.frame_end  = 1'b0;
      add_expected(exp_row);
      above_row  = center_row;
      center_row = row;
      // bottom row goes out unchanged and closes the frame
      if (row_idx + 1 >= h) begin
        exp_row.cells      = row;
        exp_row.row_number = ROW_IDX_W'(row_idx);
        exp_row.frame_end  = 1'b1;
        add_expected(exp_row);
        row_idx = 0;
      end else begin
        row_idx = row_idx + 1;
      end
    endfunction

    // one accepted result against the oldest expectation
    task check_row(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
      smoothed_row_t exp_row;
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, tdata %h", tdata));
        return;
      end
      exp_row = expected_rows.pop_front();
      rows_checked++;
      if (tlast) frames_checked++;
      if (tdata[ROW_W-1:0] !== exp_row.cells)
        report_mismatch($sformatf("row %0d cells %h, expected %h", exp_row.row_number,
                                  tdata[ROW_W-1:0], exp_row.cells));
      if (tdata[ROW_W +: ROW_IDX_W] !== exp_row.row_number)
        report_mismatch($sformatf("row number %0d, expected %0d",
                                  tdata[ROW_W +: ROW_IDX_W], exp_row.row_number));
      if (tdata[OUT_TDATA_W-1:ROW_W+ROW_IDX_W] !== '0)
        report_mismatch($sformatf("row %0d nonzero fill bits %h", exp_row.row_number,
                                  tdata[OUT_TDATA_W-1:ROW_W+ROW_IDX_W]));
      if (tlast !== exp_row.frame_end)
        report_mismatch($sformatf("row %0d tlast %b, expected %b", exp_row.row_number,
                                  tlast, exp_row.frame_end));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_we = 1'b0;
  cfg_idx_t               cfg_index = CFG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int unsigned src_idle_pct  = 37;
  int unsigned sink_idle_pct = 86;
  int unsigned quiet_cycles  = 0;

  majority_scoreboard sb = new();

  binary_grid_majority_smoother dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_row(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // one row transfer on s_axis, with a random gap ahead of it
  task send_row(logic [ROW_W-1:0] cells);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cells;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_row(cells);
  endtask

  // stop sending and let every expected result come out
  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_config(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // row content of mixed density so every window count turns up
  function logic [ROW_W-1:0] random_cells();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return a & b;
      5, 6, 7: return a | b;
      default: return a;
    endcase
  endfunction

  // runs of whole frames, sometimes cut short, each under a fresh setting
  task run_frames(int unsigned n_rows);
    int unsigned sent;
    int unsigned rows;
    int unsigned h_eff;
    logic [CFG_DATA_W-1:0] wv;
    logic [CFG_DATA_W-1:0] hv;
    sent = 0;
    while (sent < n_rows) begin
      // width: upper data bits are outside the register
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(5))
          0: wv = 0;
          1: wv = 2;
          2: wv = 3;
          3: wv = 64;
          4: wv = 65;
          default: wv = 127;
        endcase
      end else begin
        wv = CFG_DATA_W'($urandom_range(3, 64));
      end
      wv[CFG_DATA_W-1:GRID_W_W] = (CFG_DATA_W - GRID_W_W)'($urandom);
      if ($urandom_range(7) == 0) hv = CFG_DATA_W'($urandom_range(0, 3));
      else hv = CFG_DATA_W'($urandom_range(3, 10));
      write_reg(CFG_GRID_WIDTH, wv);
      write_reg(CFG_GRID_HEIGHT, hv);
      h_eff = sb.height_now();
      rows  = h_eff * $urandom_range(1, 3);
      if ($urandom_range(3) == 0) rows += $urandom_range(h_eff - 1);
      repeat (rows) send_row(random_cells());
      sent += rows;
      drain();
    end
  endtask

  // stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // narrowest grid: width and height both saturate up to 3
    write_reg(CFG_GRID_WIDTH, 0);
    write_reg(CFG_GRID_HEIGHT, 0);
    // wall center with a count of exactly four, stray bits past the width
    send_row(64'hFFFF_FFFF_FFFF_FFF3);
    send_row(64'h0000_0000_0000_0002);
    send_row(64'hA5A5_0000_0000_0001);
    // floor center with a count of exactly four
    send_row(64'h0000_0000_0000_0007);
    send_row(64'h0000_0000_0000_0000);
    send_row(64'h0000_0000_0000_0001);
    // all wall
    repeat (3) send_row('1);
    drain();

    // widest grid with width saturating down, height just below the floor
    write_reg(CFG_GRID_WIDTH, 127);
    write_reg(CFG_GRID_HEIGHT, 2);
    send_row('0);
    send_row('1);
    send_row('0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA);
    send_row(64'h5555_5555_5555_5555);
    send_row(64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // a write in the middle of a frame starts a new one
    send_row(64'h0F0F_0F0F_0F0F_0F0F);
    send_row(64'hF0F0_F0F0_F0F0_F0F0);
    drain();
    write_reg(CFG_GRID_HEIGHT, 4);
    repeat (4) send_row(random_cells());
    drain();

    // random frames, sender idle 37 and receiver idle 86 of a hundred
    run_frames(180);

    src_idle_pct  = 86;
    sink_idle_pct = 37;
    run_frames(180);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_frames(180);

    // height above the register range saturates down, frame left open
    write_reg(CFG_GRID_WIDTH, 64);
    write_reg(CFG_GRID_HEIGHT, 2047);
    repeat (24) send_row(random_cells());
    drain();

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    $display("covered %0d rows in, %0d results checked over %0d frames",
             sb.rows_in, sb.rows_checked, sb.frames_checked);
    $display("%0d register writes, widths at both saturation ends, heights out of range",
             sb.cfg_writes);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/bgms_pkg.sv
rtl/core/bgms_lane.sv
rtl/core/bgms_row.sv
rtl/core/bgms_out_fifo.sv
rtl/core/binary_grid_majority_smoother.sv
rtl/core/bgms_checker.sv
verif/tb_top.sv
